// ===== rtl/core/atsf_pkg.sv =====
// Shared constants and codes for the affine texture span fill block.
package atsf_pkg;

    localparam int TEX_ADDR_BITS_DEF = 16;
    localparam int SPAN_BITS_DEF     = 12;

    localparam int TEXEL_BITS     = 8;
    localparam int PAL_ADDR_BITS  = 8;
    localparam int COLOUR_BITS    = 16;
    localparam int ACC_BITS       = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef logic [1:0] t_action;

    localparam t_action ACT_LOAD_TEX = 2'd0;
    localparam t_action ACT_LOAD_PAL = 2'd1;
    localparam t_action ACT_START    = 2'd2;
    localparam t_action ACT_PIXEL    = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_SHIFT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TEXEL_MASK  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_U_STEP      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_V_STEP      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASKED_MODE = 3'd4;

endpackage

// ===== rtl/core/affine_texture_span_fill.sv =====
// Palettized affine texture span fill: texel store, palette store and span walker.
// An accepted pixel transaction is registered by the texture read, then the palette read,
// and then by the output register before its result shows.
// Throughput: one transaction per cycle; input stalls only while a held result blocks a full pipe.
// Reset clears configuration (mask to all ones), accumulators, span counters and all pipeline valids.
// Texture and palette stores are not cleared; no entry may be read before it is loaded.
module affine_texture_span_fill #(
    parameter int TEXTURE_ADDRESS_BITS = atsf_pkg::TEX_ADDR_BITS_DEF,
    parameter int SPAN_COUNT_BITS      = atsf_pkg::SPAN_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [atsf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [atsf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_action,
    input  logic [15:0]                         i_load_address,
    input  logic [15:0]                         i_load_data,
    input  logic signed [31:0]                  i_start_u,
    input  logic signed [31:0]                  i_start_v,
    input  logic [SPAN_COUNT_BITS-1:0]          i_span_length,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [SPAN_COUNT_BITS-1:0]          o_pixel_position,
    output logic [15:0]                         o_pixel_colour,
    output logic                                o_write_enable,
    output logic                                o_last_pixel
);
    import atsf_pkg::*;

    localparam int TAB = TEXTURE_ADDRESS_BITS;
    localparam int SCB = SPAN_COUNT_BITS;

    logic [4:0]          r_width_shift;
    logic [15:0]         r_texel_mask;
    logic [ACC_BITS-1:0] r_u_step;
    logic [ACC_BITS-1:0] r_v_step;
    logic                r_masked_mode;

    logic [ACC_BITS-1:0] r_u_acc, n_u_acc;
    logic [ACC_BITS-1:0] r_v_acc, n_v_acc;
    logic [SCB-1:0]      r_remaining, n_remaining;
    logic [SCB-1:0]      r_count, n_count;

    logic                   r_s1_pix;
    logic                   r_s1_pal_we;
    logic [PAL_ADDR_BITS-1:0] r_s1_pal_addr;
    logic [COLOUR_BITS-1:0] r_s1_pal_data;
    logic [SCB-1:0]         r_s1_pos;
    logic                   r_s1_last;

    logic                   r_s2_valid;
    logic [SCB-1:0]         r_s2_pos;
    logic                   r_s2_last;
    logic                   r_s2_we;

    logic                   r_o_valid;
    logic [SCB-1:0]         r_o_pos;
    logic [COLOUR_BITS-1:0] r_o_colour;
    logic                   r_o_we;
    logic                   r_o_last;

    logic                   w_en;
    logic                   w_accept;
    logic                   w_emit;
    logic                   w_tex_we;
    logic                   w_pal_load;
    logic [15:0]            w_row;
    logic [15:0]            w_sum;
    logic [31:0]            w_rd_addr32;
    logic [31:0]            w_wr_addr32;
    logic [TAB-1:0]         w_tex_rd_addr;
    logic [TAB-1:0]         w_tex_wr_addr;
    logic [TEXEL_BITS-1:0]  w_tex_rdata;
    logic [COLOUR_BITS-1:0] w_pal_rdata;

    assign w_en       = !r_s2_valid || !r_o_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_accept   = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_shift <= '0;
            r_texel_mask  <= 16'hFFFF;
            r_u_step      <= '0;
            r_v_step      <= '0;
            r_masked_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH_SHIFT: r_width_shift <= i_cfg_data[4:0];
                REG_TEXEL_MASK:  r_texel_mask  <= i_cfg_data[15:0];
                REG_U_STEP:      r_u_step      <= i_cfg_data;
                REG_V_STEP:      r_v_step      <= i_cfg_data;
                REG_MASKED_MODE: r_masked_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_row         = r_v_acc[31:16] << r_width_shift;
    assign w_sum         = w_row + r_u_acc[31:16];
    assign w_rd_addr32   = {16'b0, w_sum & r_texel_mask};
    assign w_tex_rd_addr = w_rd_addr32[TAB-1:0];
    assign w_wr_addr32   = {16'b0, i_load_address};
    assign w_tex_wr_addr = w_wr_addr32[TAB-1:0];

    always_comb begin
        n_u_acc     = r_u_acc;
        n_v_acc     = r_v_acc;
        n_remaining = r_remaining;
        n_count     = r_count;
        w_emit      = 1'b0;
        w_tex_we    = 1'b0;
        w_pal_load  = 1'b0;
        if (w_accept) begin
            unique case (i_action)
                ACT_LOAD_TEX: w_tex_we = 1'b1;
                ACT_LOAD_PAL: w_pal_load = 1'b1;
                ACT_START: begin
                    n_u_acc     = i_start_u;
                    n_v_acc     = i_start_v;
                    n_remaining = i_span_length;
                    n_count     = '0;
                end
                ACT_PIXEL: begin
                    if (r_remaining != '0) begin
                        w_emit      = 1'b1;
                        n_u_acc     = r_u_acc + r_u_step;
                        n_v_acc     = r_v_acc + r_v_step;
                        n_remaining = r_remaining - SCB'(1);
                        n_count     = r_count + SCB'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_acc     <= '0;
            r_v_acc     <= '0;
            r_remaining <= '0;
            r_count     <= '0;
        end else begin
            r_u_acc     <= n_u_acc;
            r_v_acc     <= n_v_acc;
            r_remaining <= n_remaining;
            r_count     <= n_count;
        end
    end

    atsf_ram #(
        .WIDTH      (TEXEL_BITS),
        .DEPTH_BITS (TAB)
    ) u_tex_ram (
        .i_clk      (i_clk),
        .i_wr_en    (w_tex_we),
        .i_wr_addr  (w_tex_wr_addr),
        .i_wr_data  (i_load_data[TEXEL_BITS-1:0]),
        .i_rd_en    (w_en),
        .i_rd_addr  (w_tex_rd_addr),
        .o_rd_data  (w_tex_rdata)
    );

    atsf_ram #(
        .WIDTH      (COLOUR_BITS),
        .DEPTH_BITS (PAL_ADDR_BITS)
    ) u_pal_ram (
        .i_clk      (i_clk),
        .i_wr_en    (w_en && r_s1_pal_we),
        .i_wr_addr  (r_s1_pal_addr),
        .i_wr_data  (r_s1_pal_data),
        .i_rd_en    (w_en),
        .i_rd_addr  (w_tex_rdata),
        .o_rd_data  (w_pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pix    <= 1'b0;
            r_s1_pal_we <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (w_en) begin
                r_s1_pix    <= w_emit;
                r_s1_pal_we <= w_pal_load;
                r_s2_valid  <= r_s1_pix;
            end
            r_o_valid <= (w_en && r_s2_valid) || (r_o_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pal_addr <= i_load_address[PAL_ADDR_BITS-1:0];
            r_s1_pal_data <= i_load_data;
            r_s1_pos      <= r_count;
            r_s1_last     <= (r_remaining == SCB'(1));
            r_s2_pos      <= r_s1_pos;
            r_s2_last     <= r_s1_last;
            r_s2_we       <= !(r_masked_mode && (w_tex_rdata == '0));
            if (r_s2_valid) begin
                r_o_pos    <= r_s2_pos;
                r_o_last   <= r_s2_last;
                r_o_we     <= r_s2_we;
                r_o_colour <= r_s2_we ? w_pal_rdata : '0;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_pixel_position = r_o_pos;
    assign o_pixel_colour   = r_o_colour;
    assign o_write_enable   = r_o_we;
    assign o_last_pixel     = r_o_last;

    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !$past(r_o_valid)) |-> $past(r_s2_valid))
        else $error("result appeared without a pixel in the last stage");

    a_pal_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_pal_rdata))
        else $error("palette read data changed during a stall");

    a_span_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_remaining == SCB'(1)) |=> (r_remaining == '0))
        else $error("span did not end after its last pixel");

endmodule

// ===== rtl/core/atsf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module atsf_ram #(
    parameter int WIDTH      = atsf_pkg::TEXEL_BITS,
    parameter int DEPTH_BITS = atsf_pkg::TEX_ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [DEPTH_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]      i_wr_data,
    input  logic                  i_rd_en,
    input  logic [DEPTH_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]      o_rd_data
);
    import atsf_pkg::*;

    localparam int DEPTH = 1 << DEPTH_BITS;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sim/atsf_span_checker.sv =====
// Checker for the affine texture span fill: predicts each pixel and compares the output channel.
module atsf_span_checker #(
    parameter int TEX_BITS  = atsf_pkg::TEX_ADDR_BITS_DEF,
    parameter int SPAN_BITS = atsf_pkg::SPAN_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [atsf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [atsf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,

    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  atsf_pkg::t_action                   i_action,
    input  logic [15:0]                         i_load_address,
    input  logic [15:0]                         i_load_data,
    input  logic signed [31:0]                  i_start_u,
    input  logic signed [31:0]                  i_start_v,
    input  logic [SPAN_BITS-1:0]                i_span_length,

    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [SPAN_BITS-1:0]                i_pixel_position,
    input  logic [15:0]                         i_pixel_colour,
    input  logic                                i_write_enable,
    input  logic                                i_last_pixel,

    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import atsf_pkg::*;

    typedef struct packed {
        logic [SPAN_BITS-1:0] position;
        logic [15:0]          colour;
        logic                 write_en;
        logic                 last;
    } t_pixel;

    t_pixel pending_pixels[$];

    logic [4:0]         row_shift;
    logic [15:0]        wrap_mask;
    logic signed [31:0] u_step;
    logic signed [31:0] v_step;
    logic               key_enable;

    logic signed [31:0]   u_acc;
    logic signed [31:0]   v_acc;
    logic [SPAN_BITS-1:0] span_left;
    logic [SPAN_BITS-1:0] span_pos;

    bit [7:0]  texel_mem [1 << TEX_BITS];
    bit [15:0] palette_mem [256];

    task automatic note_mismatch(input string what);
        $display("%t pixel mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic walk_span_item();
        logic signed [31:0]  u_int;
        logic signed [31:0]  v_int;
        logic [31:0]         sum;
        logic [TEX_BITS-1:0] addr;
        logic [7:0]          index;
        t_pixel              px;
        case (i_action)
            ACT_LOAD_TEX: texel_mem[i_load_address[TEX_BITS-1:0]] = i_load_data[7:0];
            ACT_LOAD_PAL: palette_mem[i_load_address[7:0]] = i_load_data;
            ACT_START: begin
                u_acc     = i_start_u;
                v_acc     = i_start_v;
                span_left = i_span_length;
                span_pos  = '0;
            end
            ACT_PIXEL: begin
                if (span_left != 0) begin
                    u_int = u_acc >>> 16;
                    v_int = v_acc >>> 16;
                    sum   = (v_int << row_shift) + u_int;
                    addr  = TEX_BITS'(sum & {16'h0000, wrap_mask});
                    index = texel_mem[addr];
                    px.position = span_pos;
                    px.write_en = !(key_enable && index == 8'h00);
                    px.colour   = px.write_en ? palette_mem[index] : 16'h0000;
                    px.last     = (span_left == 1);
                    pending_pixels.push_back(px);
                    u_acc     = u_acc + u_step;
                    v_acc     = v_acc + v_step;
                    span_left = span_left - 1'b1;
                    span_pos  = span_pos + 1'b1;
                end
            end
        endcase
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (pending_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected pixel at position %0d", i_pixel_position));
            return;
        end
        want = pending_pixels.pop_front();
        if (i_pixel_position !== want.position) begin
            note_mismatch($sformatf("position %0d, expected %0d",
                                    i_pixel_position, want.position));
        end
        if (i_pixel_colour !== want.colour) begin
            note_mismatch($sformatf("colour %h at position %0d, expected %h",
                                    i_pixel_colour, want.position, want.colour));
        end
        if (i_write_enable !== want.write_en) begin
            note_mismatch($sformatf("write enable %b at position %0d, expected %b",
                                    i_write_enable, want.position, want.write_en));
        end
        if (i_last_pixel !== want.last) begin
            note_mismatch($sformatf("last flag %b at position %0d, expected %b",
                                    i_last_pixel, want.position, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_shift  = '0;
            wrap_mask  = 16'hFFFF;
            u_step     = '0;
            v_step     = '0;
            key_enable = 1'b0;
            u_acc      = '0;
            v_acc      = '0;
            span_left  = '0;
            span_pos   = '0;
            pending_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH_SHIFT: row_shift  = i_cfg_data[4:0];
                    REG_TEXEL_MASK:  wrap_mask  = i_cfg_data[15:0];
                    REG_U_STEP:      u_step     = i_cfg_data;
                    REG_V_STEP:      v_step     = i_cfg_data;
                    REG_MASKED_MODE: key_enable = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                check_pixel();
            end
            if (i_in_valid && i_in_ready) begin
                walk_span_item();
            end
        end
        o_pending = pending_pixels.size();
    end

endmodule

// ===== sim/affine_texture_span_fill_test.sv =====
// Testbench top for the affine texture span fill: reset, register setup, span traffic, verdict.
module affine_texture_span_fill_test;
    timeunit 1ns;
    timeprecision 1ps;

    import atsf_pkg::*;

    localparam int TEX_BITS    = TEX_ADDR_BITS_DEF;
    localparam int SPAN_BITS   = SPAN_BITS_DEF;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_CYCLES = 60;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd5;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    t_action                   i_action = ACT_LOAD_TEX;
    logic [15:0]               i_load_address = '0;
    logic [15:0]               i_load_data = '0;
    logic signed [31:0]        i_start_u = '0;
    logic signed [31:0]        i_start_v = '0;
    logic [SPAN_BITS-1:0]      i_span_length = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [SPAN_BITS-1:0]      o_pixel_position;
    logic [15:0]               o_pixel_colour;
    logic                      o_write_enable;
    logic                      o_last_pixel;

    int fail_count;
    int pending_count;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int fed_items = 0;

    // Address tracking so that every texel and palette entry is loaded before it is read.
    logic [4:0]           plan_shift = '0;
    logic [15:0]          plan_mask = 16'hFFFF;
    logic [31:0]          plan_ustep = '0;
    logic [31:0]          plan_vstep = '0;
    logic [31:0]          plan_u = '0;
    logic [31:0]          plan_v = '0;
    logic [SPAN_BITS-1:0] plan_left = '0;
    bit [7:0]             tex_val [1 << TEX_BITS];
    bit                   tex_known [1 << TEX_BITS];
    bit                   pal_known [256];

    affine_texture_span_fill dut (.*);

    atsf_span_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_load_address   (i_load_address),
        .i_load_data      (i_load_data),
        .i_start_u        (i_start_u),
        .i_start_v        (i_start_v),
        .i_span_length    (i_span_length),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_pixel_position (o_pixel_position),
        .i_pixel_colour   (o_pixel_colour),
        .i_write_enable   (o_write_enable),
        .i_last_pixel     (o_last_pixel),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    // Hold off the output for a long stretch on request, else stall at random.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    function automatic logic [15:0] texel_word();
        return {8'($urandom), ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom)};
    endfunction

    task automatic send_item(input t_action act, input logic [15:0] addr,
                             input logic [15:0] data, input logic [31:0] su,
                             input logic [31:0] sv, input logic [SPAN_BITS-1:0] len);
        if (act != ACT_PIXEL || plan_left != 0) begin
            fed_items++;
        end
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_load_address <= addr;
        i_load_data    <= data;
        i_start_u      <= su;
        i_start_v      <= sv;
        i_span_length  <= len;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic load_texel(input logic [15:0] addr, input logic [15:0] data);
        tex_val[addr[TEX_BITS-1:0]]   = data[7:0];
        tex_known[addr[TEX_BITS-1:0]] = 1'b1;
        send_item(ACT_LOAD_TEX, addr, data, $urandom, $urandom, SPAN_BITS'($urandom));
    endtask

    task automatic load_palette(input logic [15:0] addr, input logic [15:0] data);
        pal_known[addr[7:0]] = 1'b1;
        send_item(ACT_LOAD_PAL, addr, data, $urandom, $urandom, SPAN_BITS'($urandom));
    endtask

    task automatic start_span(input logic [31:0] su, input logic [31:0] sv,
                              input logic [SPAN_BITS-1:0] len);
        plan_u    = su;
        plan_v    = sv;
        plan_left = len;
        send_item(ACT_START, 16'($urandom), 16'($urandom), su, sv, len);
    endtask

    task automatic paint_pixel();
        logic [31:0] sum;
        logic [15:0] addr;
        logic [7:0]  index;
        if (plan_left != 0) begin
            sum  = ({{16{plan_v[31]}}, plan_v[31:16]} << plan_shift)
                   + {{16{plan_u[31]}}, plan_u[31:16]};
            addr = sum[15:0] & plan_mask;
            if (!tex_known[addr[TEX_BITS-1:0]]) begin
                load_texel(addr, texel_word());
            end
            index = tex_val[addr[TEX_BITS-1:0]];
            if (!pal_known[index]) begin
                load_palette({8'($urandom), index}, 16'($urandom));
            end
        end
        send_item(ACT_PIXEL, 16'($urandom), 16'($urandom), $urandom, $urandom,
                  SPAN_BITS'($urandom));
        if (plan_left != 0) begin
            plan_u    = plan_u + plan_ustep;
            plan_v    = plan_v + plan_vstep;
            plan_left = plan_left - 1'b1;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic [31:0] data);
        case (index)
            REG_WIDTH_SHIFT: plan_shift = data[4:0];
            REG_TEXEL_MASK:  plan_mask  = data[15:0];
            REG_U_STEP:      plan_ustep = data;
            REG_V_STEP:      plan_vstep = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic configure_phase(input int ph);
        logic [31:0] shift;
        logic [31:0] mask;
        logic [31:0] us;
        logic [31:0] vs;
        logic [31:0] key;
        case (ph)
            0: {shift, mask, us, vs, key} = {32'd4, 32'h00FF, 32'h0001_0000, 32'h0000_4000, 32'd0};
            1: {shift, mask, us, vs, key} = {32'd31, 32'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                             32'd1};
            2: {shift, mask, us, vs, key} = {32'd0, 32'h0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                             32'd0};
            3: {shift, mask, us, vs, key} = {32'd8, 32'hFFFF, $urandom, $urandom, 32'd1};
            4: {shift, mask, us, vs, key} = {32'd6, 32'h0FFF, 32'hFFFF_8000, 32'h0001_8000,
                                             32'd1};
            5: {shift, mask, us, vs, key} = {32'd16, 32'hF0F0, $urandom, $urandom, 32'd0};
            default: {shift, mask, us, vs, key} = {$urandom, $urandom, $urandom, $urandom,
                                                   $urandom};
        endcase
        write_reg(REG_WIDTH_SHIFT, shift);
        write_reg(REG_TEXEL_MASK, mask);
        write_reg(REG_U_STEP, us);
        write_reg(REG_V_STEP, vs);
        write_reg(REG_MASKED_MODE, key);
        if (ph % 2 == 1) begin
            write_reg(REG_SPARE_LO + 3'($urandom_range(2)), $urandom);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int budget);
        int goal;
        int len;
        int n;
        goal = fed_items + budget;
        while (fed_items < goal) begin
            case ($urandom_range(9))
                0: begin
                    if ($urandom_range(1) == 0) begin
                        load_texel(16'($urandom), texel_word());
                    end else begin
                        load_palette(16'($urandom), 16'($urandom));
                    end
                end
                1: paint_pixel();
                default: begin
                    case ($urandom_range(15))
                        0:       len = 0;
                        1:       len = 4095;
                        2:       len = $urandom_range(4095);
                        default: len = $urandom_range(1, 20);
                    endcase
                    start_span($urandom, $urandom, SPAN_BITS'(len));
                    n = (len > 24) ? $urandom_range(1, 24) : len;
                    if ($urandom_range(3) == 0) begin
                        n = n + $urandom_range(1, 2);
                    end else if ($urandom_range(7) == 0 && n > 0) begin
                        n = $urandom_range(0, n - 1);
                    end
                    repeat (n) paint_pixel();
                end
            endcase
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        load_palette(16'hFF00, 16'h0000);
        load_palette(16'h00FF, 16'hFFFF);
        load_texel(16'h0000, 16'hFFFF);
        load_texel(16'hFFFF, 16'h0000);
        start_span(32'h8000_0000, 32'h7FFF_FFFF, 4095);
        repeat (3) paint_pixel();
        start_span(32'h0000_0000, 32'h0000_0000, 0);
        repeat (2) paint_pixel();
        start_span(32'hFFFF_FFFF, 32'h0001_0000, 1);
        repeat (2) paint_pixel();
        start_span(32'h7FFF_FFFF, 32'h8000_0000, 2);
        repeat (2) paint_pixel();

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            configure_phase(ph);
            case (ph % 4)
                0:       {in_idle_pct, out_stall_pct} = {32'd0, 32'd0};
                1:       {in_idle_pct, out_stall_pct} = {32'd50, 32'd0};
                2:       {in_idle_pct, out_stall_pct} = {32'd0, 32'd50};
                default: {in_idle_pct, out_stall_pct} = {32'd19, 32'd19};
            endcase
            if (ph == 0) begin
                hold_req++;
                start_span($urandom, $urandom, SPAN_BITS'(48));
                repeat (48) paint_pixel();
            end
            run_traffic(PHASE_ITEMS);
        end

        i_in_valid <= 1'b0;
        for (int w = 0; w < 20000 && pending_count != 0; w++) begin
            @(negedge i_clk);
        end
        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
